// ===== design/segment_plot_distance_lookup_macros.svh =====
// Assertion helpers used by the lookup design file.
`ifndef SEGMENT_PLOT_DISTANCE_LOOKUP_MACROS_SVH
`define SEGMENT_PLOT_DISTANCE_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spl_pkg.sv =====
package spl_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int TWO_PI_Q12       = 25736;
    localparam int SUM_MAX          = 4194303;
    localparam int FRAC_ONE         = 65536;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_END_HEADING  = 2'd0,
        CFG_END_PRESSURE = 2'd1,
        CFG_ROTATION     = 2'd2,
        CFG_SMOOTH_MODE  = 2'd3
    } t_cfg_idx;

    // status of the serial divider towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // heading difference wrapped into [-pi, pi], ties to an even quotient
    function automatic logic signed [15:0] wrap_angle(input logic signed [16:0] diff);
        logic signed [18:0] sh;
        logic [2:0]         qp;
        logic signed [18:0] r;
        sh = 19'(diff) + 19'(3 * TWO_PI_Q12);
        qp = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            if (sh >= 19'(k * TWO_PI_Q12)) begin
                qp = 3'(k);
            end
        end
        r = sh - 19'(int'(qp) * TWO_PI_Q12);
        // quotient is qp - 3, so it is odd when qp is even
        if ((r * 2 > TWO_PI_Q12) || ((r * 2 == TWO_PI_Q12) && !qp[0])) begin
            r = r - 19'(TWO_PI_Q12);
        end
        return 16'(r);
    endfunction

endpackage

// ===== design/spl_ram.sv =====
module spl_ram import spl_pkg::*; #(
    parameter int WIDTH = 48,
    parameter int DEPTH = MAX_SEGMENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/spl_div.sv =====
// Restoring divider, one quotient bit per cycle. Dividend below divisor.
module spl_div import spl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [15:0] i_divisor,
    output t_div_stat   o_stat,
    output logic [15:0] o_quot
);

    logic [15:0] r_rem, n_rem;
    logic [15:0] r_quot, n_quot;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] rem2;
    logic        ge;

    always_comb begin
        rem2   = {r_rem, 1'b0};
        ge     = rem2 >= {1'b0, r_dvs};
        n_rem  = ge ? 16'(rem2 - {1'b0, r_dvs}) : rem2[15:0];
        n_quot = {r_quot[14:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dvs  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_quot;

endmodule

// ===== design/segment_plot_distance_lookup.sv =====
// Segment plot distance lookup.
// Input stream (i_s_*): one transaction per command. tuser carries the kind
// (clear, append, query); tdata carries segment heading, length, pressure and
// the query distance. Output stream (o_m_*): exactly one result transaction
// per command, tuser is the status flag (append refused, table full).
// Config channel (i_cfg_*): register index and data, always ready; write only
// while the block is idle.
// Flow: clear, append and unused kinds and a query on an empty table go
// straight to the result. A query walks the segment table one entry a
// cycle through the single read port of the segment memory, takes the
// following segment or the end values, divides for the fraction and then
// interpolates; the serial divider is skipped when the segment has zero
// length or the distance reaches or passes its end.
// One command in flight; a new one is taken once the previous result sits
// in the output register, even if the receiver has not taken it yet.
// Receiver stall: the output register holds its transaction; a finished
// command then waits in its last state, and no new input is accepted.
// Reset (synchronous, active low): table empty, length sum and config
// registers zero, output empty. The segment memory itself is not cleared.
`include "segment_plot_distance_lookup_macros.svh"
module segment_plot_distance_lookup import spl_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [15:0] seg_heading, [31:16] seg_length, [47:32] seg_pressure,
    // [69:48] query_distance, [71:70] zero
    input  logic [71:0] i_s_tdata,
    // [1:0] kind
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [17:0] heading_out, [33:18] pressure_out, [55:34] total_length,
    // [62:56] segment_count, [63] zero
    output logic [63:0] o_m_tdata,
    // [0] status
    output logic        o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW   = $clog2(MAX_SEGMENTS);
    localparam int CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int SW   = 16 + AW;             // exact cumulative length
    localparam int CMPW = (SW > 22) ? SW : 22;

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_NEXT, S_DIVS, S_DIV, S_MULP, S_MULH, S_DONE
    } t_state;

    // config registers
    logic signed [15:0] r_end_head;
    logic [15:0]        r_end_press;
    logic signed [15:0] r_rot;
    logic               r_smooth;

    // table bookkeeping
    logic [CW-1:0] r_count;
    logic [21:0]   r_sum;

    // sequencer
    t_state             r_state;
    logic [AW-1:0]      r_idx;
    logic [SW-1:0]      r_start;
    logic [21:0]        r_dist;
    logic [21:0]        r_diff;
    logic [15:0]        r_len;
    logic signed [15:0] r_from_h, r_to_h;
    logic [15:0]        r_from_p, r_to_p;
    logic [16:0]        r_frac;
    logic signed [15:0] r_delta;
    logic signed [34:0] r_prod;
    logic signed [17:0] r_res_head;
    logic [15:0]        r_res_press;
    logic               r_res_stat;
    logic               r_head_interp;

    // output register
    logic        r_mvalid;
    logic [63:0] r_mdata;
    logic        r_muser;

    // memory
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [47:0]   ram_rdata;

    // divider
    logic      div_start;
    t_div_stat div_stat;
    logic [15:0] div_quot;

    // combinational
    logic               s_acc;
    logic [1:0]         in_kind;
    logic signed [15:0] in_head;
    logic [15:0]        in_len, in_press;
    logic [21:0]        in_dist;
    logic signed [15:0] rd_head;
    logic [15:0]        rd_len, rd_press;
    logic [SW-1:0]      nxt;
    logic [CMPW-1:0]    dist_x, nxt_x, start_x, diff_x;
    logic               last, stop;
    logic [22:0]        sum_add;
    logic               load_out;
    logic signed [16:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] prod_rnd;
    logic [CW+6:0]      cnt_wide;
    logic signed [17:0] head_final;

    assign in_head  = i_s_tdata[15:0];
    assign in_len   = i_s_tdata[31:16];
    assign in_press = i_s_tdata[47:32];
    assign in_dist  = i_s_tdata[69:48];
    assign in_kind  = i_s_tuser;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign rd_head  = ram_rdata[15:0];
    assign rd_len   = ram_rdata[31:16];
    assign rd_press = ram_rdata[47:32];

    // walk step: does the distance end within segment r_idx
    always_comb begin
        nxt     = r_start + SW'(rd_len);
        dist_x  = CMPW'(r_dist);
        nxt_x   = CMPW'(nxt);
        start_x = CMPW'(r_start);
        diff_x  = dist_x - ((dist_x > start_x) ? start_x : dist_x);
        last    = (CW'(r_idx) + CW'(1)) >= r_count;
        stop    = (dist_x <= nxt_x) || last;
    end

    assign ram_we    = s_acc && (in_kind == KIND_APPEND) && (r_count < CW'(MAX_SEGMENTS));
    assign ram_raddr = (r_state == S_IDLE) ? '0 : AW'(r_idx + AW'(1));
    assign sum_add   = {1'b0, r_sum} + 23'(in_len);
    assign div_start = (r_state == S_DIVS) && (r_len != 16'd0) && (r_diff < 22'(r_len));

    // shared multiplier: pressure delta first, then heading delta
    always_comb begin
        if (r_state == S_MULP) begin
            mul_a = $signed({1'b0, r_to_p}) - $signed({1'b0, r_from_p});
        end else begin
            mul_a = 17'(r_delta);
        end
        mul_b    = $signed({1'b0, r_frac});
        prod_rnd = (36'(r_prod) + 36'sd32768) >>> 16;
    end

    assign load_out = (r_state == S_DONE) && (!r_mvalid || i_m_tready);

    // heading interpolation term joins in the output load
    assign head_final = r_head_interp ? 18'(36'(r_res_head) + prod_rnd) : r_res_head;
    assign cnt_wide   = (CW + 7)'(r_count);

    spl_ram #(
        .WIDTH (48),
        .DEPTH (MAX_SEGMENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({in_press, in_len, in_head}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    spl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_diff[15:0]),
        .i_divisor  (r_len),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_head  <= '0;
            r_end_press <= '0;
            r_rot       <= '0;
            r_smooth    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_END_HEADING:  r_end_head  <= i_cfg_data;
                CFG_END_PRESSURE: r_end_press <= i_cfg_data;
                CFG_ROTATION:     r_rot       <= i_cfg_data;
                CFG_SMOOTH_MODE:  r_smooth    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer, table state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_sum         <= '0;
            r_mvalid      <= 1'b0;
            r_head_interp <= 1'b0;
        end else begin
            if (load_out) begin
                r_mvalid <= 1'b1;
                r_mdata  <= {1'b0, cnt_wide[6:0], r_sum, r_res_press, head_final};
                r_muser  <= r_res_stat;
            end else if (i_m_tready) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_head_interp <= 1'b0;
                    if (s_acc) begin
                        r_res_stat  <= 1'b0;
                        r_res_head  <= '0;
                        r_res_press <= '0;
                        r_idx       <= '0;
                        r_start     <= '0;
                        r_dist      <= in_dist;
                        r_state     <= S_DONE;
                        case (t_kind'(in_kind))
                            KIND_CLEAR: begin
                                r_count <= '0;
                                r_sum   <= '0;
                            end
                            KIND_APPEND: begin
                                if (r_count >= CW'(MAX_SEGMENTS)) begin
                                    r_res_stat <= 1'b1;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                    r_sum   <= (sum_add > 23'(SUM_MAX)) ? 22'(SUM_MAX)
                                                                        : sum_add[21:0];
                                end
                            end
                            KIND_QUERY: begin
                                if (r_count == '0) begin
                                    r_res_head  <= 18'(r_end_head) + 18'(r_rot);
                                    r_res_press <= r_end_press;
                                end else begin
                                    r_state <= S_WALK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    if (stop) begin
                        r_from_h <= rd_head;
                        r_from_p <= rd_press;
                        r_len    <= rd_len;
                        r_diff   <= 22'(diff_x);
                        r_to_h   <= r_end_head;
                        r_to_p   <= r_end_press;
                        r_state  <= last ? S_DIVS : S_NEXT;
                    end else begin
                        r_start <= nxt;
                        r_idx   <= AW'(r_idx + AW'(1));
                    end
                end
                S_NEXT: begin
                    r_to_h  <= rd_head;
                    r_to_p  <= rd_press;
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        // zero length gives no fraction; past the end caps at one
                        r_frac  <= (r_len == 16'd0) ? 17'd0 : 17'(FRAC_ONE);
                        r_state <= S_MULP;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_frac  <= {1'b0, div_quot};
                        r_state <= S_MULP;
                    end
                end
                S_MULP: begin
                    r_prod  <= 35'(mul_a) * 35'(mul_b);
                    r_delta <= wrap_angle(17'(r_to_h) - 17'(r_from_h));
                    r_state <= S_MULH;
                end
                S_MULH: begin
                    r_res_press   <= (r_len == 16'd0) ? r_to_p
                                                      : 16'(36'(r_from_p) + prod_rnd);
                    r_prod        <= 35'(mul_a) * 35'(mul_b);
                    r_head_interp <= r_smooth && (r_len != 16'd0);
                    r_state       <= S_DONE;
                    if (!r_smooth || r_len == 16'd0) begin
                        r_res_head <= 18'(r_from_h) + 18'(r_rot);
                    end else begin
                        // product registered in this state is read in S_DONE
                        r_res_head <= 18'(r_from_h) + 18'(r_rot);
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;

    `SPL_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_SEGMENTS),
        "segment count above table size")
    `SPL_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, ram_we,
        r_count == $past(r_count) + CW'(1), "append did not grow the table")
    `SPL_ASSERT_NOW(a_div_done_state, i_clk, i_rst_n, div_stat.done, r_state == S_DIV,
        "divider finished outside the divide state")
    `SPL_ASSERT_NOW(a_div_busy, i_clk, i_rst_n, (r_state == S_DIV) && !div_stat.done,
        div_stat.busy, "divider idle in the divide state")
    `SPL_ASSERT_NOW(a_walk_in_table, i_clk, i_rst_n, r_state == S_WALK,
        CW'(r_idx) < r_count, "walk beyond stored segments")

endmodule
